// ===== rtl/efr_pkg.sv =====
package efr_pkg;

  localparam int unsigned BufDepth = 256;
  localparam int unsigned AddrW    = $clog2(BufDepth);
  localparam int unsigned CntW     = $clog2(BufDepth + 1);
  localparam int unsigned HdrBytes = 4;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_READ = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef enum logic {
    CMD_RX   = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_ESCAPE  = 2'd0,
    REG_HEAD    = 2'd1,
    REG_LITERAL = 2'd2
  } reg_idx_e;

  // Result as it leaves the staging slot, before the buffer data is merged in
  typedef struct packed {
    kind_e       kind;
    logic [15:0] frame_cmd;
    logic [15:0] inner_len;
    logic [15:0] total_len;
    logic        oob;
  } stage_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] frame_cmd;
    logic [15:0] inner_len;
    logic [15:0] total_len;
    logic [7:0]  read_data;
  } result_t;

endpackage

// ===== rtl/escaped_frame_receiver.sv =====
// Byte-stuffed frame receiver. One item is accepted per cycle, back to back,
// while in_stall_o is low: a received byte updates the small framing state and
// makes at most one write into the frame buffer, and a read request makes one
// read of it. The frame buffer is a single memory with one registered read
// port, so an item's result is held first in a staging slot while the buffer
// read completes, then in a two-entry output buffer. Input stall rises only
// when the staging slot and both output entries are all occupied. Frame header
// bytes are shadowed in flops so a completed frame reports without extra
// buffer reads. Configuration registers are written through cfg_we_i/cfg_idx_i.
module escaped_frame_receiver (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           read_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           result_kind_o,
  output logic [15:0]          frame_cmd_o,
  output logic [15:0]          frame_data_len_o,
  output logic [15:0]          frame_total_len_o,
  output logic [7:0]           read_data_o
);
  import efr_pkg::*;

  // configuration
  logic [7:0] esc_byte_q, head_byte_q, lit_byte_q;

  // framing state
  phase_e          phase_q, phase_d;
  logic            esc_q, esc_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [15:0]     exp_len_q, exp_len_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      hdr_q [HdrBytes];
  logic [7:0]      hdr_d [HdrBytes];

  // frame buffer
  logic [7:0]       mem [BufDepth];
  logic [7:0]       rdata_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  // staging slot and output buffer
  logic    s1_valid_q, s1_valid_d;
  stage_t  s1_q, s1_d;
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, s1_res;
  logic    push, pop, accept;

  logic            res_valid;
  stage_t          res;
  logic [7:0]      b_eff;
  logic            data_ok;
  logic [15:0]     len_new;
  logic [CntW-1:0] cnt_inc;
  logic [8:0]      rd_idx;

  assign accept = in_valid_i && !in_stall_o;
  assign push   = s1_valid_q && !skid_valid_q;
  assign pop    = out_valid_q && !out_stall_i;

  assign in_stall_o = s1_valid_q && skid_valid_q;

  assign rd_idx    = {1'b0, read_index_i} + 9'(HdrBytes);
  assign mem_raddr = rd_idx[AddrW-1:0];
  assign mem_re    = accept && (cmd_i == CMD_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_byte_q  <= 8'd165;
      head_byte_q <= 8'd90;
      lit_byte_q  <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ESCAPE:  esc_byte_q  <= cfg_wdata_i;
        REG_HEAD:    head_byte_q <= cfg_wdata_i;
        REG_LITERAL: lit_byte_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Framing next state and buffer write
  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    len_hi_d  = len_hi_q;
    exp_len_d = exp_len_q;
    cnt_d     = cnt_q;
    hdr_d     = hdr_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AddrW-1:0];
    mem_wdata = 8'd0;
    res_valid = 1'b0;
    res       = '0;
    b_eff     = rx_byte_i;
    data_ok   = 1'b0;
    len_new   = {len_hi_q, rx_byte_i};
    cnt_inc   = cnt_q + CntW'(1);

    if (accept && (cmd_i == CMD_READ)) begin
      res_valid = 1'b1;
      res.kind  = KIND_READ;
      res.oob   = ({8'd0, rd_idx} >= 17'(BufDepth));
    end else if (accept) begin
      if (phase_q == PH_HUNT) begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (rx_byte_i == head_byte_q) phase_d = PH_LEN_HI;
        end else begin
          esc_d = (rx_byte_i == esc_byte_q);
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == lit_byte_q) begin
          b_eff   = esc_byte_q;
          data_ok = 1'b1;
        end else begin
          phase_d = (rx_byte_i == head_byte_q) ? PH_LEN_HI : PH_HUNT;
        end
      end else if (rx_byte_i == esc_byte_q) begin
        esc_d = 1'b1;
      end else begin
        data_ok = 1'b1;
      end

      if (data_ok) begin
        len_new = {len_hi_q, b_eff};
        case (phase_q)
          PH_LEN_HI: begin
            len_hi_d = b_eff;
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            esc_d     = 1'b0;
            exp_len_d = len_new;
            cnt_d     = '0;
            if (len_new < 16'(HdrBytes) || {1'b0, len_new} > 17'(BufDepth)) begin
              phase_d       = PH_HUNT;
              res_valid     = 1'b1;
              res.kind      = KIND_BAD;
              res.total_len = len_new;
            end else begin
              phase_d = PH_DATA;
            end
          end
          PH_DATA: begin
            mem_we    = 1'b1;
            mem_wdata = b_eff;
            if (cnt_q < CntW'(HdrBytes)) hdr_d[cnt_q[1:0]] = b_eff;
            cnt_d = cnt_inc;
            if ({{(16 - CntW){1'b0}}, cnt_inc} == exp_len_q) begin
              phase_d       = PH_HUNT;
              esc_d         = 1'b0;
              res_valid     = 1'b1;
              res.kind      = KIND_DONE;
              res.frame_cmd = {hdr_d[0], hdr_d[1]};
              res.inner_len = {hdr_d[2], hdr_d[3]};
              res.total_len = exp_len_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      esc_q     <= 1'b0;
      len_hi_q  <= 8'd0;
      exp_len_q <= 16'd0;
      cnt_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      esc_q     <= esc_d;
      len_hi_q  <= len_hi_d;
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // Staging slot: holds one result until the output buffer has room
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (push) s1_valid_d = 1'b0;
    if (accept) begin
      s1_valid_d = res_valid;
      s1_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= s1_valid_d;
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  always_comb begin
    s1_res.kind      = s1_q.kind;
    s1_res.frame_cmd = s1_q.frame_cmd;
    s1_res.inner_len = s1_q.inner_len;
    s1_res.total_len = s1_q.total_len;
    s1_res.read_data = (s1_q.kind == KIND_READ && !s1_q.oob) ? rdata_q : 8'd0;
  end

  // Two-entry output buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        out_valid_q  <= skid_valid_q || push;
        skid_valid_q <= skid_valid_q && push;
      end else if (push) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= out_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= s1_res;
      end else begin
        out_q <= s1_res;
      end
    end else if (push) begin
      if (out_valid_q) skid_q <= s1_res;
      else             out_q  <= s1_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.kind;
  assign frame_cmd_o       = out_q.frame_cmd;
  assign frame_data_len_o  = out_q.inner_len;
  assign frame_total_len_o = out_q.total_len;
  assign read_data_o       = out_q.read_data;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> ({{(16 - CntW){1'b0}}, cnt_q} < exp_len_q))
    else $error("stored count reached frame length without completion");

  a_data_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |->
      (exp_len_q >= 16'(HdrBytes) && {1'b0, exp_len_q} <= 17'(BufDepth)))
    else $error("data phase entered with an out-of-range length");

  a_read_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_READ) |=> (s1_valid_q && s1_q.kind == KIND_READ))
    else $error("read item did not reach the staging slot");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !push) |-> in_stall_o)
    else $error("input taken while a staged result was blocked");

endmodule

// ===== bench/tb_escaped_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_escaped_frame_receiver;
  import efr_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 8;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic [1:0] cfg_idx_i    = REG_ESCAPE;
  logic [7:0] cfg_wdata_i  = 8'h00;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic       cmd_i        = CMD_RX;
  logic [7:0] rx_byte_i    = 8'h00;
  logic [7:0] read_index_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [1:0] result_kind_o;
  logic [15:0] frame_cmd_o;
  logic [15:0] frame_data_len_o;
  logic [15:0] frame_total_len_o;
  logic [7:0] read_data_o;

  escaped_frame_receiver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .rx_byte_i        (rx_byte_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .frame_cmd_o      (frame_cmd_o),
    .frame_data_len_o (frame_data_len_o),
    .frame_total_len_o(frame_total_len_o),
    .read_data_o      (read_data_o)
  );

  // Tracks the deframer state and the results each accepted item should cause
  class frame_checker;
    logic [7:0]  esc_b;
    logic [7:0]  head_b;
    logic [7:0]  lit_b;
    phase_e      phase;
    bit          esc_pend;
    logic [7:0]  len_hi;
    logic [15:0] exp_len;
    int unsigned count;
    logic [7:0]  store [BufDepth];
    bit          written [BufDepth];
    result_t     pending_results [$];
    int unsigned errors;

    function new();
      esc_b    = 8'd165;
      head_b   = 8'd90;
      lit_b    = 8'd0;
      phase    = PH_HUNT;
      esc_pend = 1'b0;
      len_hi   = 8'h00;
      exp_len  = 16'h0000;
      count    = 0;
      errors   = 0;
      foreach (store[i]) begin
        store[i]   = 8'h00;
        written[i] = 1'b0;
      end
    endfunction

    function void set_reg(reg_idx_e r, logic [7:0] v);
      case (r)
        REG_ESCAPE:  esc_b = v;
        REG_HEAD:    head_b = v;
        REG_LITERAL: lit_b = v;
        default: ;
      endcase
    endfunction

    function void push(kind_e k, logic [15:0] fc, logic [15:0] dl, logic [15:0] tl,
                       logic [7:0] rd);
      result_t r;
      r.kind      = k;
      r.frame_cmd = fc;
      r.inner_len = dl;
      r.total_len = tl;
      r.read_data = rd;
      pending_results.push_back(r);
    endfunction

    function void note_item(cmd_e c, logic [7:0] rx, logic [7:0] ridx);
      int unsigned addr;
      logic [7:0]  b;
      logic [15:0] len;
      b = rx;
      if (c == CMD_READ) begin
        addr = ridx + HdrBytes;
        push(KIND_READ, 16'h0, 16'h0, 16'h0, (addr < BufDepth) ? store[addr] : 8'h00);
        return;
      end
      if (phase == PH_HUNT) begin
        if (esc_pend) begin
          esc_pend = 1'b0;
          if (b == head_b) phase = PH_LEN_HI;
        end else begin
          esc_pend = (b == esc_b);
        end
        return;
      end
      // literal test wins over the head test outside the hunt
      if (esc_pend) begin
        esc_pend = 1'b0;
        if (b == lit_b) begin
          b = esc_b;
        end else begin
          phase = (b == head_b) ? PH_LEN_HI : PH_HUNT;
          return;
        end
      end else if (b == esc_b) begin
        esc_pend = 1'b1;
        return;
      end
      case (phase)
        PH_LEN_HI: begin
          len_hi = b;
          phase  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len      = {len_hi, b};
          exp_len  = len;
          count    = 0;
          esc_pend = 1'b0;
          if (len < HdrBytes || len > BufDepth) begin
            phase = PH_HUNT;
            push(KIND_BAD, 16'h0, 16'h0, len, 8'h00);
          end else begin
            phase = PH_DATA;
          end
        end
        default: begin
          if (count < BufDepth) begin
            store[count]   = b;
            written[count] = 1'b1;
          end
          count++;
          if (count == exp_len) begin
            phase    = PH_HUNT;
            esc_pend = 1'b0;
            push(KIND_DONE, {store[0], store[1]}, {store[2], store[3]}, exp_len, 8'h00);
          end
        end
      endcase
    endfunction

    function void compare(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s: expected %0h, got %0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] k, logic [15:0] fc, logic [15:0] dl,
                               logic [15:0] tl, logic [7:0] rd);
      result_t e;
      if (pending_results.size() == 0) begin
        $error("result_kind: expected no result, got %0d", k);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare("result_kind", e.kind, k);
      compare("frame_cmd", e.frame_cmd, fc);
      compare("frame_data_len", e.inner_len, dl);
      compare("frame_total_len", e.total_len, tl);
      compare("read_data", e.read_data, rd);
    endfunction
  endclass

  frame_checker sb = new();

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_on    = 1'b0;
  event        hold_go;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= hold_on || ($urandom_range(0, 99) < stall_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input
  initial begin
    forever begin
      @(hold_go);
      hold_on = 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(result_kind_o, frame_cmd_o, frame_data_len_o, frame_total_len_o,
                      read_data_o);
    end
  end

  task automatic send(input cmd_e c, input logic [7:0] rx, input logic [7:0] ridx);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= c;
    rx_byte_i    <= rx;
    read_index_i <= ridx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(c, rx, ridx);
    sent_count++;
  endtask

  task automatic send_rx(input logic [7:0] b);
    send(CMD_RX, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_read(input logic [7:0] idx);
    send(CMD_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  // Escape a data byte that collides with the escape value
  task automatic send_data(input logic [7:0] b);
    if (b == sb.esc_b) begin
      send_rx(sb.esc_b);
      send_rx(sb.lit_b);
    end else begin
      send_rx(b);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e r, input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(r, v);
  endtask

  task automatic write_regs(input logic [7:0] e, input logic [7:0] h, input logic [7:0] l);
    write_reg(REG_ESCAPE, e);
    write_reg(REG_HEAD, h);
    write_reg(REG_LITERAL, l);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return sb.esc_b;
      1: return sb.head_b;
      2: return sb.lit_b;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Only point at entries already written, or past the end of the store
  function automatic logic [7:0] pick_read_index();
    int unsigned k;
    int unsigned a;
    if ($urandom_range(0, 19) == 0) return 8'(252 + $urandom_range(0, 3));
    k = $urandom_range(0, 251);
    for (int j = 0; j < 252; j++) begin
      a = HdrBytes + (k + j) % 252;
      if (sb.written[a]) return 8'(a - HdrBytes);
    end
    return 8'(252 + $urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 62) return 16'($urandom_range(HdrBytes, 24));
    if (r < 77) return 16'($urandom_range(25, 64));
    if (r < 80) return 16'($urandom_range(65, 249));
    if (r < 84) return 16'($urandom_range(250, BufDepth));
    if (r < 88) return 16'($urandom_range(0, HdrBytes - 1));
    if (r < 92) return 16'($urandom_range(BufDepth + 1, 511));
    if (r < 95) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic return_to_hunt();
    logic [7:0] f;
    do f = 8'($urandom_range(0, 255));
    while (f == sb.esc_b || f == sb.head_b || f == sb.lit_b);
    while (sb.phase != PH_HUNT || sb.esc_pend) begin
      if (sb.phase != PH_HUNT && !sb.esc_pend) send_rx(sb.esc_b);
      else send_rx(f);
    end
  endtask

  task automatic send_frame(input logic [15:0] len, input int unsigned n_body);
    send_rx(sb.esc_b);
    send_rx(sb.head_b);
    send_data(len[15:8]);
    send_data(len[7:0]);
    for (int unsigned i = 0; i < n_body; i++) begin
      send_data(pick_byte());
      if ($urandom_range(0, 9) == 0) send_read(pick_read_index());
    end
  endtask

  task automatic random_step();
    int unsigned r;
    int unsigned n;
    logic [15:0] len;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      len = pick_len();
      n = 0;
      if (len >= HdrBytes && len <= BufDepth) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : len;
      end
      // now and then skip the cleanup to resync in the middle of a frame
      if ($urandom_range(0, 4) != 0) return_to_hunt();
      send_frame(len, n);
    end else if (r < 75) begin
      repeat ($urandom_range(1, 4)) send_read(pick_read_index());
    end else if (r < 88) begin
      repeat ($urandom_range(1, 6)) send_rx(pick_byte());
    end else begin
      send_rx(sb.esc_b);
      send_rx(pick_byte());
    end
  endtask

  logic [7:0]  reg_tab [NumPhases][3];
  int unsigned idle_tab [4] = '{0, 82, 0, 19};
  int unsigned stall_tab [4] = '{0, 0, 82, 19};
  int unsigned goal;

  initial begin
    reg_tab = '{
      '{8'd165, 8'd90, 8'd0},
      '{8'h00, 8'hFF, 8'h01},
      '{8'hFF, 8'h00, 8'hFF},
      '{8'h7E, 8'h7E, 8'h5D},
      '{8'h33, 8'h44, 8'h44},
      '{8'hFF, 8'hFF, 8'hFF},
      '{8'h00, 8'h00, 8'h00},
      '{8'h00, 8'h00, 8'h00}
    };
    reg_tab[NumPhases-1][0] = 8'($urandom_range(0, 255));
    reg_tab[NumPhases-1][1] = 8'($urandom_range(0, 255));
    reg_tab[NumPhases-1][2] = 8'($urandom_range(0, 255));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reads past the store, a short frame with an escaped byte,
    // bad lengths (one with an escaped low byte), reads of stored data
    send_read(8'd255);
    send_read(8'd252);
    send_rx(sb.esc_b);
    send_rx(sb.head_b);
    send_rx(8'h00);
    send_rx(8'h05);
    send_rx(8'hFF);
    send_rx(sb.esc_b);
    send_rx(sb.lit_b);
    send_rx(8'h00);
    send_rx(8'hFF);
    send_rx(8'h7F);
    send_read(8'd0);
    send_rx(sb.esc_b);
    send_rx(sb.head_b);
    send_rx(8'h00);
    send_rx(8'h00);
    send_rx(sb.esc_b);
    send_rx(sb.head_b);
    send_rx(8'h01);
    send_rx(sb.esc_b);
    send_rx(sb.lit_b);
    // escape flag must be clear here, so this byte stays ignored
    send_rx(sb.head_b);
    send_read(8'd0);

    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain();
      write_regs(reg_tab[p][0], reg_tab[p][1], reg_tab[p][2]);
      idle_pct  = idle_tab[p % 4];
      stall_pct = stall_tab[p % 4];
      goal = sent_count + PhaseItems;
      if (p == 0) begin
        -> hold_go;
        repeat (12) send_read(pick_read_index());
      end
      while (sent_count < goal) random_step();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
